/* rtl/fltm_pkg.sv */
// Shared types and constants for the four-level page table mapper.
package fltm_pkg;

   localparam int unsigned IDX_W = 9;
   localparam int unsigned ENTRY_W = 64;
   localparam int unsigned VA_W = 48;
   localparam int unsigned PA_W = 32;
   localparam int unsigned PFN_W = 20;
   localparam int unsigned PAGE_SHIFT = 12;
   localparam int unsigned LEVELS = 4;

   localparam logic [PFN_W-1:0] POOL_BASE_RESET = 20'd256;
   localparam logic [2:0] LINK_FLAGS = 3'b111;
   localparam logic [1:0] LEAF_LEVEL = 2'd3;
   localparam logic [2:0] ROOT_NEED = 3'd4;

   localparam logic STATUS_MAPPED = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_WALK   = 7'b0000100,
      ST_CHECK  = 7'b0001000,
      ST_ALLOC  = 7'b0010000,
      ST_WRITE  = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

endpackage

/* rtl/four_level_page_table_mapper_top.sv */
// Flow: a request transfer moves the block from idle to the walk; once stopped it goes
// straight to the response. Each table read passes the walk and check states, the pool
// check is the alloc state, each table write the write state, and the finish state
// registers the response. One request at a time, and a waiting response holds the next.
// After reset the memory is cleared one entry per cycle and req_ready stays low until
// the clearing pass ends; reset clears pool, root and stopped flag, and the base is 256.
module four_level_page_table_mapper_top #(
   parameter int unsigned POOL_PAGES = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [fltm_pkg::PFN_W-1:0]      csr_wr_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [fltm_pkg::VA_W-1:0]       req_virtual_address,
   input  logic [fltm_pkg::PA_W-1:0]       req_physical_address,
   input  logic                            req_writable,
   input  logic                            req_executable,
   input  logic                            req_kernel_only,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_status,
   output logic [31:0]                     rsp_root_address,
   output logic [6:0]                      rsp_tables_used,
   output logic [2:0]                      rsp_tables_added
);

   localparam int unsigned SLOT_W = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
   localparam int unsigned CNT_W = $clog2(POOL_PAGES + 1);
   localparam int unsigned ADDR_W = SLOT_W + fltm_pkg::IDX_W;
   localparam int unsigned DEPTH = POOL_PAGES * 512;

   fltm_pkg::state_type state_ff, state_in;

   logic [fltm_pkg::PFN_W-1:0]  base_ff, base_in;
   logic [CNT_W-1:0]            nf_ff, nf_in;
   logic                        root_present_ff, root_present_in;
   logic                        stopped_ff, stopped_in;

   logic [fltm_pkg::IDX_W-1:0]  idx_ff [fltm_pkg::LEVELS];
   logic [fltm_pkg::IDX_W-1:0]  idx_in [fltm_pkg::LEVELS];
   logic [fltm_pkg::PA_W-1:0]   pa_ff, pa_in;
   logic                        wr_flag_ff, wr_flag_in;
   logic                        ex_flag_ff, ex_flag_in;
   logic                        kern_flag_ff, kern_flag_in;
   logic [1:0]                  level_ff, level_in;
   logic [SLOT_W-1:0]           cur_ff, cur_in;
   logic [2:0]                  added_ff, added_in;
   logic                        err_ff, err_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_status_ff, rsp_status_in;
   logic [31:0]                 rsp_root_ff, rsp_root_in;
   logic [6:0]                  rsp_used_ff, rsp_used_in;
   logic [2:0]                  rsp_added_ff, rsp_added_in;

   logic                         st_rd_en;
   logic [ADDR_W-1:0]            st_rd_addr;
   logic [fltm_pkg::ENTRY_W-1:0] st_rd_data;
   logic                         st_wr_en;
   logic [ADDR_W-1:0]            st_wr_addr;
   logic [fltm_pkg::ENTRY_W-1:0] st_wr_data;
   logic                         st_busy;

   logic [fltm_pkg::PFN_W-1:0]  entry_rel;
   logic [fltm_pkg::PFN_W-1:0]  new_pfn;
   logic [2:0]                  need;
   logic [CNT_W:0]              demand;

   fltm_table_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .busy    (st_busy)
   );

   // Slot a present entry points to, relative to the current pool base.
   assign entry_rel = st_rd_data[31:12] - base_ff;
   assign new_pfn = base_ff + fltm_pkg::PFN_W'(nf_ff);
   assign need = root_present_ff ? (3'd3 - {1'b0, level_ff}) : fltm_pkg::ROOT_NEED;
   assign demand = (CNT_W + 1)'(nf_ff) + (CNT_W + 1)'(need);

   always_comb begin
      state_in = state_ff;
      base_in = base_ff;
      nf_in = nf_ff;
      root_present_in = root_present_ff;
      stopped_in = stopped_ff;
      for (int i = 0; i < fltm_pkg::LEVELS; i++) begin
         idx_in[i] = idx_ff[i];
      end
      pa_in = pa_ff;
      wr_flag_in = wr_flag_ff;
      ex_flag_in = ex_flag_ff;
      kern_flag_in = kern_flag_ff;
      level_in = level_ff;
      cur_in = cur_ff;
      added_in = added_ff;
      err_in = err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_root_in = rsp_root_ff;
      rsp_used_in = rsp_used_ff;
      rsp_added_in = rsp_added_ff;
      st_rd_en = 1'b0;
      st_rd_addr = {cur_ff, idx_ff[level_ff]};
      st_wr_en = 1'b0;
      st_wr_addr = {cur_ff, idx_ff[level_ff]};
      st_wr_data = {32'd0, new_pfn, 9'd0, fltm_pkg::LINK_FLAGS};

      if (csr_wr_en) begin
         base_in = csr_wr_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         fltm_pkg::ST_CLEAR: begin
            if (!st_busy) begin
               state_in = fltm_pkg::ST_IDLE;
            end
         end
         fltm_pkg::ST_IDLE: begin
            if (req_valid) begin
               idx_in[0] = req_virtual_address[47:39];
               idx_in[1] = req_virtual_address[38:30];
               idx_in[2] = req_virtual_address[29:21];
               idx_in[3] = req_virtual_address[20:12];
               pa_in = req_physical_address;
               wr_flag_in = req_writable;
               ex_flag_in = req_executable;
               kern_flag_in = req_kernel_only;
               level_in = '0;
               cur_in = '0;
               added_in = '0;
               err_in = 1'b0;
               state_in = fltm_pkg::ST_WALK;
            end
         end
         fltm_pkg::ST_WALK: begin
            if (stopped_ff) begin
               err_in = 1'b1;
               state_in = fltm_pkg::ST_FINISH;
            end else if (!root_present_ff) begin
               state_in = fltm_pkg::ST_ALLOC;
            end else begin
               st_rd_en = 1'b1;
               state_in = fltm_pkg::ST_CHECK;
            end
         end
         fltm_pkg::ST_CHECK: begin
            if (!st_rd_data[0]) begin
               state_in = fltm_pkg::ST_ALLOC;
            end else if (entry_rel >= fltm_pkg::PFN_W'(nf_ff)) begin
               // The entry points outside the allocated pool, e.g. after a base move.
               err_in = 1'b1;
               stopped_in = 1'b1;
               state_in = fltm_pkg::ST_FINISH;
            end else begin
               cur_in = entry_rel[SLOT_W-1:0];
               level_in = level_ff + 2'd1;
               if (level_ff == 2'd2) begin
                  state_in = fltm_pkg::ST_ALLOC;
               end else begin
                  state_in = fltm_pkg::ST_WALK;
               end
            end
         end
         fltm_pkg::ST_ALLOC: begin
            if (demand > (CNT_W + 1)'(POOL_PAGES)) begin
               err_in = 1'b1;
               stopped_in = 1'b1;
               state_in = fltm_pkg::ST_FINISH;
            end else begin
               if (!root_present_ff) begin
                  root_present_in = 1'b1;
                  nf_in = nf_ff + CNT_W'(1);
                  added_in = 3'd1;
                  cur_in = '0;
               end
               state_in = fltm_pkg::ST_WRITE;
            end
         end
         fltm_pkg::ST_WRITE: begin
            st_wr_en = 1'b1;
            if (level_ff == fltm_pkg::LEAF_LEVEL) begin
               st_wr_data = {~ex_flag_ff, 31'd0, pa_ff[31:3], ~kern_flag_ff, wr_flag_ff,
                             1'b1};
               state_in = fltm_pkg::ST_FINISH;
            end else begin
               // Link the next free slot below this entry and descend into it.
               cur_in = nf_ff[SLOT_W-1:0];
               nf_in = nf_ff + CNT_W'(1);
               added_in = added_ff + 3'd1;
               level_in = level_ff + 2'd1;
            end
         end
         fltm_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = err_ff ? fltm_pkg::STATUS_ERROR : fltm_pkg::STATUS_MAPPED;
               rsp_root_in = root_present_ff ? {base_ff, 12'd0} : 32'd0;
               rsp_used_in = 7'(nf_ff);
               rsp_added_in = added_ff;
               state_in = fltm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fltm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fltm_pkg::ST_CLEAR;
         base_ff <= fltm_pkg::POOL_BASE_RESET;
         nf_ff <= '0;
         root_present_ff <= 1'b0;
         stopped_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_ff <= base_in;
         nf_ff <= nf_in;
         root_present_ff <= root_present_in;
         stopped_ff <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < fltm_pkg::LEVELS; i++) begin
         idx_ff[i] <= idx_in[i];
      end
      pa_ff <= pa_in;
      wr_flag_ff <= wr_flag_in;
      ex_flag_ff <= ex_flag_in;
      kern_flag_ff <= kern_flag_in;
      level_ff <= level_in;
      cur_ff <= cur_in;
      added_ff <= added_in;
      err_ff <= err_in;
      rsp_status_ff <= rsp_status_in;
      rsp_root_ff <= rsp_root_in;
      rsp_used_ff <= rsp_used_in;
      rsp_added_ff <= rsp_added_in;
   end

   assign req_ready = (state_ff == fltm_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_root_address = rsp_root_ff;
   assign rsp_tables_used = rsp_used_ff;
   assign rsp_tables_added = rsp_added_ff;

`ifndef SYNTHESIS
   a_no_req_during_clear: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !st_busy)
      else $error("request transfer while the table store is being cleared");

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      nf_ff <= CNT_W'(POOL_PAGES))
      else $error("pool allocation beyond the pool size");

   a_stopped_sticky: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("stopped flag cleared without reset");

   a_error_adds_nothing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == fltm_pkg::STATUS_ERROR) |-> rsp_added_ff == 3'd0)
      else $error("failed mapping reports allocated tables");

   a_mapped_has_root: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == fltm_pkg::STATUS_MAPPED) |-> root_present_ff)
      else $error("mapped response without a root table");
`endif

endmodule

/* rtl/fltm_table_store.sv */
// Table store: single-port-write, registered-read memory with a clearing pass after reset.
module fltm_table_store #(
   parameter int unsigned DEPTH = 32768,
   parameter int unsigned ADDR_W = 15
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rd_en,
   input  logic [ADDR_W-1:0]                  rd_addr,
   output logic [fltm_pkg::ENTRY_W-1:0]       rd_data,
   input  logic                               wr_en,
   input  logic [ADDR_W-1:0]                  wr_addr,
   input  logic [fltm_pkg::ENTRY_W-1:0]       wr_data,
   output logic                               busy
);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   logic [fltm_pkg::ENTRY_W-1:0] mem [DEPTH];
   logic [fltm_pkg::ENTRY_W-1:0] rd_data_ff;
   logic                         busy_ff;
   logic                         busy_in;
   logic [ADDR_W-1:0]            clr_addr_ff;
   logic [ADDR_W-1:0]            clr_addr_in;

   always_comb begin
      busy_in = busy_ff;
      clr_addr_in = clr_addr_ff;
      if (busy_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // The clearing pass owns the write port until every entry is zero.
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy = busy_ff;

endmodule

/* tb/mapping_checker.sv */
// Checker for the page table mapper: predicts each response from the accepted requests.
module mapping_checker #(
   parameter int unsigned POOL_PAGES = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [fltm_pkg::PFN_W-1:0] csr_wr_data,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [fltm_pkg::VA_W-1:0]  req_virtual_address,
   input  logic [fltm_pkg::PA_W-1:0]  req_physical_address,
   input  logic                       req_writable,
   input  logic                       req_executable,
   input  logic                       req_kernel_only,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic                       rsp_status,
   input  logic [31:0]                rsp_root_address,
   input  logic [6:0]                 rsp_tables_used,
   input  logic [2:0]                 rsp_tables_added,
   input  logic                       drained,
   output int                         mismatch_count
);

   localparam int unsigned TABLE_ENTRIES = 512;

   typedef struct packed {
      logic        status;
      logic [31:0] root_address;
      logic [6:0]  tables_used;
      logic [2:0]  tables_added;
   } mapping_result_type;

   // Model copy of the table memory; entries that were never written read as zero.
   logic [fltm_pkg::ENTRY_W-1:0] table_image [int unsigned];
   int unsigned                  slots_taken;
   bit                           root_live;
   bit                           halted;
   logic [fltm_pkg::PFN_W-1:0]   pool_base;
   mapping_result_type           awaited_responses [$];
   int unsigned                  responses_seen;
   bit                           drain_checked;

   initial mismatch_count = 0;

   function automatic logic [31:0] page_address(input int unsigned slot);
      logic [fltm_pkg::PFN_W-1:0] pfn;
      pfn = pool_base + fltm_pkg::PFN_W'(slot);
      return {pfn, 12'h000};
   endfunction

   function automatic logic [fltm_pkg::ENTRY_W-1:0] fetch_entry(input int unsigned pos);
      if (table_image.exists(pos)) begin
         return table_image[pos];
      end
      return '0;
   endfunction

   // Slot a present entry points to under the current pool base, or -1 if none.
   function automatic int entry_to_slot(input logic [fltm_pkg::ENTRY_W-1:0] entry);
      logic [fltm_pkg::PFN_W-1:0] rel;
      rel = entry[31:12] - pool_base;
      if (rel >= slots_taken || rel >= POOL_PAGES) begin
         return -1;
      end
      return int'(rel);
   endfunction

   function automatic int unsigned claim_slot();
      int unsigned slot;
      slot = slots_taken;
      for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
         table_image.delete(slot * TABLE_ENTRIES + i);
      end
      slots_taken = slot + 1;
      return slot;
   endfunction

   function automatic mapping_result_type predict_mapping(
      input logic [fltm_pkg::VA_W-1:0] va,
      input logic [fltm_pkg::PA_W-1:0] pa,
      input logic                      writable,
      input logic                      executable,
      input logic                      kernel_only
   );
      logic [fltm_pkg::IDX_W-1:0]   idx [fltm_pkg::LEVELS];
      int unsigned                  need;
      int unsigned                  added;
      int unsigned                  cur;
      int unsigned                  pos;
      int                           found;
      bit                           bad;
      logic [fltm_pkg::ENTRY_W-1:0] entry;
      mapping_result_type           res;
      idx[0] = va[47:39];
      idx[1] = va[38:30];
      idx[2] = va[29:21];
      idx[3] = va[20:12];
      need = 0;
      added = 0;
      cur = 0;
      bad = halted;
      // The whole walk is checked before anything is written.
      if (!bad) begin
         if (!root_live) begin
            need = fltm_pkg::LEVELS;
         end else begin
            for (int lvl = 0; lvl < 3; lvl++) begin
               entry = fetch_entry(cur * TABLE_ENTRIES + idx[lvl]);
               if (!entry[0]) begin
                  need = 3 - lvl;
                  break;
               end
               found = entry_to_slot(entry);
               if (found < 0) begin
                  bad = 1'b1;
                  break;
               end
               cur = found;
            end
         end
         if (!bad && slots_taken + need > POOL_PAGES) begin
            bad = 1'b1;
         end
      end
      if (bad) begin
         halted = 1'b1;
      end else begin
         if (!root_live) begin
            void'(claim_slot());
            root_live = 1'b1;
            added++;
         end
         cur = 0;
         for (int lvl = 0; lvl < 3; lvl++) begin
            pos = cur * TABLE_ENTRIES + idx[lvl];
            entry = fetch_entry(pos);
            if (!entry[0]) begin
               cur = claim_slot();
               table_image[pos] = {32'h0, page_address(cur)} | 64'h7;
               added++;
            end else begin
               found = entry_to_slot(entry);
               cur = (found < 0) ? 0 : found;
            end
         end
         table_image[cur * TABLE_ENTRIES + idx[3]] =
            {~executable, 31'h0, pa[31:3], ~kernel_only, writable, 1'b1};
      end
      res.status = bad ? fltm_pkg::STATUS_ERROR : fltm_pkg::STATUS_MAPPED;
      res.root_address = root_live ? page_address(0) : 32'h0;
      res.tables_used = 7'(slots_taken);
      res.tables_added = 3'(added);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("checker: response %0d: %s: got 0x%0h, expected 0x%0h",
               responses_seen, what, got, want);
   endtask

   always @(posedge clock) begin
      mapping_result_type want;
      if (reset) begin
         table_image.delete();
         slots_taken = 0;
         root_live = 1'b0;
         halted = 1'b0;
         pool_base = fltm_pkg::POOL_BASE_RESET;
         awaited_responses.delete();
         responses_seen = 0;
         drain_checked = 1'b0;
      end else begin
         if (csr_wr_en) begin
            pool_base = csr_wr_data;
         end
         if (req_valid && req_ready) begin
            awaited_responses.push_back(predict_mapping(req_virtual_address,
               req_physical_address, req_writable, req_executable, req_kernel_only));
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_responses.size() == 0) begin
               report_mismatch("response with no mapping pending", 32'(rsp_status), 32'd0);
            end else begin
               want = awaited_responses.pop_front();
               if (rsp_status !== want.status) begin
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               end
               if (rsp_root_address !== want.root_address) begin
                  report_mismatch("root_address", rsp_root_address, want.root_address);
               end
               if (rsp_tables_used !== want.tables_used) begin
                  report_mismatch("tables_used", 32'(rsp_tables_used),
                                  32'(want.tables_used));
               end
               if (rsp_tables_added !== want.tables_added) begin
                  report_mismatch("tables_added", 32'(rsp_tables_added),
                                  32'(want.tables_added));
               end
            end
            responses_seen++;
         end
         if (drained && !drain_checked) begin
            drain_checked = 1'b1;
            if (awaited_responses.size() != 0) begin
               report_mismatch("mappings left without a response",
                               32'(awaited_responses.size()), 32'd0);
            end
         end
      end
   end

endmodule

/* tb/testbench.sv */
// Top of the page table mapper testbench: clock, reset, stimulus, stalls and verdict.
module testbench;

   localparam int unsigned POOL_PAGES = 64;
   localparam int unsigned STALL_LIMIT = 200000;

   logic                        clock;
   logic                        reset;
   logic                        csr_wr_en;
   logic [fltm_pkg::PFN_W-1:0]  csr_wr_data;
   logic                        req_valid;
   logic                        req_ready;
   logic [fltm_pkg::VA_W-1:0]   req_virtual_address;
   logic [fltm_pkg::PA_W-1:0]   req_physical_address;
   logic                        req_writable;
   logic                        req_executable;
   logic                        req_kernel_only;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic                        rsp_status;
   logic [31:0]                 rsp_root_address;
   logic [6:0]                  rsp_tables_used;
   logic [2:0]                  rsp_tables_added;
   logic                        drained;
   int                          mismatch_count;

   int                          tx_idle_pct;
   int                          rx_idle_pct;
   int unsigned                 sent_count;
   int unsigned                 rsp_count;
   int unsigned                 stall_cycles;
   int unsigned                 stopped_sent;

   // Stimulus-side bookkeeping of which tables exist, used to spend the pool slowly.
   // An epoch is the span between two writes of the pool base.
   bit                          root_done;
   bit                          pool_stopped;
   int unsigned                 slots_used;
   int unsigned                 epoch;
   logic [fltm_pkg::PFN_W-1:0]  cur_base;
   bit                          i0_known [512];
   int unsigned                 i0_epoch [512];
   bit                          pdpt_known [logic [17:0]];
   bit                          pd_known [logic [26:0]];
   logic [26:0]                 leaf_prefixes [$];
   string                       stop_cause;

   four_level_page_table_mapper_top #(
      .POOL_PAGES(POOL_PAGES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_virtual_address(req_virtual_address),
      .req_physical_address(req_physical_address),
      .req_writable(req_writable),
      .req_executable(req_executable),
      .req_kernel_only(req_kernel_only),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_root_address(rsp_root_address),
      .rsp_tables_used(rsp_tables_used),
      .rsp_tables_added(rsp_tables_added)
   );

   mapping_checker #(
      .POOL_PAGES(POOL_PAGES)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_virtual_address(req_virtual_address),
      .req_physical_address(req_physical_address),
      .req_writable(req_writable),
      .req_executable(req_executable),
      .req_kernel_only(req_kernel_only),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_root_address(rsp_root_address),
      .rsp_tables_used(rsp_tables_used),
      .rsp_tables_added(rsp_tables_added),
      .drained(drained),
      .mismatch_count(mismatch_count)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         rsp_count <= rsp_count + 1;
      end
   end

   // The clearing pass after reset shows up here as a long stretch with no transfer.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("testbench: no transfer for %0d cycles", STALL_LIMIT);
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Pool slots a mapping would take, or -1 when it walks through a table built
   // under an earlier pool base, which the block treats as an error.
   function automatic int tables_needed(input logic [fltm_pkg::VA_W-1:0] va);
      logic [8:0] i0;
      i0 = va[47:39];
      if (!root_done) begin
         return fltm_pkg::LEVELS;
      end
      if (!i0_known[i0]) begin
         return 3;
      end
      if (i0_epoch[i0] != epoch) begin
         return -1;
      end
      if (!pdpt_known.exists(va[47:30])) begin
         return 2;
      end
      if (!pd_known.exists(va[47:21])) begin
         return 1;
      end
      return 0;
   endfunction

   function automatic void note_tables(input logic [fltm_pkg::VA_W-1:0] va, input int need);
      slots_used += need;
      root_done = 1'b1;
      if (!i0_known[va[47:39]]) begin
         i0_known[va[47:39]] = 1'b1;
         i0_epoch[va[47:39]] = epoch;
      end
      pdpt_known[va[47:30]] = 1'b1;
      if (!pd_known.exists(va[47:21])) begin
         pd_known[va[47:21]] = 1'b1;
         leaf_prefixes.push_back(va[47:21]);
      end
   endfunction

   // Fully random address; with need_fresh its root index has never been used,
   // otherwise it only avoids root entries from an earlier pool base.
   function automatic logic [fltm_pkg::VA_W-1:0] random_va(input bit need_fresh);
      logic [fltm_pkg::VA_W-1:0] va;
      do begin
         va = fltm_pkg::VA_W'({$urandom, $urandom});
      end while (i0_known[va[47:39]] && (need_fresh || i0_epoch[va[47:39]] != epoch));
      return va;
   endfunction

   function automatic logic [fltm_pkg::VA_W-1:0] reuse_va();
      logic [26:0] prefix;
      prefix = leaf_prefixes[$urandom_range(0, leaf_prefixes.size() - 1)];
      return {prefix, 9'($urandom), 12'($urandom)};
   endfunction

   task automatic send_mapping(input logic [fltm_pkg::VA_W-1:0] va,
                               input logic [fltm_pkg::PA_W-1:0] pa,
                               input logic writable, input logic executable,
                               input logic kernel_only);
      int need;
      need = tables_needed(va);
      if (pool_stopped) begin
         stopped_sent++;
      end else if (need < 0 || slots_used + need > POOL_PAGES) begin
         pool_stopped = 1'b1;
      end else begin
         note_tables(va, need);
      end
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_virtual_address <= va;
      req_physical_address <= pa;
      req_writable <= writable;
      req_executable <= executable;
      req_kernel_only <= kernel_only;
      do begin
         @(posedge clock);
      end while (!req_ready);
      sent_count++;
   endtask

   task automatic send_random(input logic [fltm_pkg::VA_W-1:0] va);
      send_mapping(va, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
   endtask

   // Hold the sender until every response is back, then let the block settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sent_count != rsp_count) begin
         @(posedge clock);
      end
      repeat (16) @(posedge clock);
   endtask

   task automatic write_base(input logic [fltm_pkg::PFN_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_base = value;
      epoch++;
      leaf_prefixes.delete();
   endtask

   // Ends the mapping life of the block: either run the pool dry or move the pool
   // base and walk an existing path, which no longer decodes.
   task automatic stop_block();
      logic [26:0] old_prefix;
      if ($urandom_range(0, 1) == 0) begin
         stop_cause = "pool exhaustion";
         while (!pool_stopped) begin
            send_random(random_va(1'b1));
         end
      end else begin
         stop_cause = "moved pool base";
         old_prefix = leaf_prefixes[$urandom_range(0, leaf_prefixes.size() - 1)];
         wait_drained();
         write_base(cur_base + fltm_pkg::PFN_W'(POOL_PAGES));
         send_random({old_prefix, 9'($urandom), 12'($urandom)});
      end
   endtask

   task automatic run_random(input int unsigned count, input int unsigned slot_cap,
                             input bit last_phase);
      logic [fltm_pkg::VA_W-1:0] va;
      int                        pick;
      int                        need;
      for (int unsigned n = 0; n < count; n++) begin
         if (last_phase && n == count * 7 / 8 && !pool_stopped) begin
            stop_block();
         end
         pick = $urandom_range(0, 99);
         if (pool_stopped) begin
            va = fltm_pkg::VA_W'({$urandom, $urandom});
         end else if (leaf_prefixes.size() == 0) begin
            va = random_va(1'b1);
         end else if (pick < 4) begin
            // A few mappings grow the tables, as far as the slot budget allows.
            va = reuse_va();
            case ($urandom_range(0, 2))
               0: va[29:21] = 9'($urandom);
               1: va[38:21] = 18'($urandom);
               default: va = random_va(1'b0);
            endcase
            need = tables_needed(va);
            if (need < 0 || slots_used + need > slot_cap) begin
               va = reuse_va();
            end
         end else begin
            va = reuse_va();
         end
         send_random(va);
      end
   endtask

   initial begin
      logic [fltm_pkg::PFN_W-1:0] mid_base;
      req_valid <= 1'b0;
      req_virtual_address <= '0;
      req_physical_address <= '0;
      req_writable <= 1'b0;
      req_executable <= 1'b0;
      req_kernel_only <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      rsp_ready <= 1'b0;
      drained <= 1'b0;
      reset <= 1'b1;
      rx_idle_pct <= 0;
      tx_idle_pct = 0;
      sent_count = 0;
      rsp_count = 0;
      stall_cycles = 0;
      stopped_sent = 0;
      root_done = 1'b0;
      pool_stopped = 1'b0;
      slots_used = 0;
      epoch = 0;
      cur_base = fltm_pkg::POOL_BASE_RESET;
      stop_cause = "none";
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // The top pool base makes slot 1 wrap around to physical address zero.
      write_base(20'hFFFFF);
      tx_idle_pct = 19;
      rx_idle_pct <= 86;
      send_mapping(48'h0, 32'h0, 1'b0, 1'b0, 1'b0);
      send_mapping(48'h0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
      send_mapping({27'h0, 9'h1FF, 12'hFFF}, 32'h1234_5678, 1'b1, 1'b0, 1'b1);
      send_mapping({18'h0, 9'h1FF, 9'h0, 12'h0}, 32'h8765_4321, 1'b0, 1'b1, 1'b0);
      send_mapping({9'h0, 9'h1FF, 18'h0, 12'h0}, 32'h0000_0FFF, 1'b1, 1'b1, 1'b0);
      send_mapping(48'hFFFF_FFFF_FFFF, 32'hFFFF_F000, 1'b0, 1'b0, 1'b1);
      send_mapping(48'hFFFF_FFFF_FFFF, 32'h0, 1'b0, 1'b1, 1'b0);
      for (int f = 0; f < 8; f++) begin
         send_mapping({27'h0, 9'(f + 8), 12'h0}, $urandom, f[0], f[1], f[2]);
      end
      send_mapping(48'hAAAA_AAAA_AAAA, 32'h5555_5555, 1'b1, 1'b0, 1'b0);
      send_mapping(48'h5555_5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b1, 1'b1);
      wait_drained();

      write_base(20'h00000);
      run_random(580, 30, 1'b0);
      wait_drained();

      tx_idle_pct = 86;
      rx_idle_pct <= 19;
      do begin
         mid_base = fltm_pkg::PFN_W'($urandom_range(1, 20'hFFFFE));
      end while (mid_base == fltm_pkg::POOL_BASE_RESET);
      write_base(mid_base);
      run_random(580, 44, 1'b0);
      wait_drained();

      tx_idle_pct = 0;
      rx_idle_pct <= 0;
      write_base(fltm_pkg::POOL_BASE_RESET);
      run_random(590, 58, 1'b1);

      wait_drained();
      repeat (30) @(posedge clock);
      drained <= 1'b1;
      repeat (2) @(posedge clock);
      $display("testbench: %0d mappings over %0d pool bases, %0d table pages built",
               sent_count, epoch, slots_used);
      $display("testbench: block stopped by %s, %0d mappings sent while stopped",
               stop_cause, stopped_sent);
      if (mismatch_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
